// ----- rtl/bldc_pkg.sv -----
// shared types, constants and small helper functions for the bldc
// command decoder and six-step commutation block; no dependencies
package bldc_pkg;

  // register map (index = paddr[3:2])
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned PADDR_W   = 4;
  localparam logic [REG_IDX_W-1:0] REG_ANGLE_OFFSET    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FORWARD_ADVANCE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_REVERSE_ADVANCE = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_HOLD_DUTY       = 2'd3;

  localparam int unsigned ANGLE_W = 12;
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned SPEED_W = 7;
  localparam int unsigned SECT_W  = 3;

  localparam logic [ANGLE_W-1:0] ANGLE_OFFSET_RST    = 12'd0;
  localparam logic [ANGLE_W-1:0] FORWARD_ADVANCE_RST = 12'd123;
  localparam logic [ANGLE_W-1:0] REVERSE_ADVANCE_RST = 12'd43;
  localparam logic [DUTY_W-1:0]  HOLD_DUTY_RST       = 8'd120;

  // start sequence and command codes
  localparam logic [7:0] START_BYTE_0 = 8'hFF;
  localparam logic [7:0] START_BYTE_1 = 8'h00;
  localparam logic [7:0] START_BYTE_2 = 8'h80;
  localparam logic [5:0] SPD_DYN_BRAKE  = 6'd62;
  localparam logic [5:0] SPD_HOLD_BRAKE = 6'd63;

  // floor(2v/195) == (2v * 10755) >> 21 for all 2v < 8192
  localparam logic [13:0] SECTOR_RECIP = 14'd10755;
  localparam int unsigned SECTOR_SHIFT = 21;
  localparam int unsigned PROD_W       = 27;
  localparam int unsigned QUOT_W       = 6;

  localparam int unsigned FIFO_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    ST_WAIT_FF = 2'd0,
    ST_WAIT_00 = 2'd1,
    ST_WAIT_80 = 2'd2,
    ST_RUN     = 2'd3
  } start_stage_e;

  typedef enum logic [1:0] {
    BRK_NONE = 2'd0,
    BRK_DYN  = 2'd1,
    BRK_HOLD = 2'd2
  } brake_mode_e;

  typedef enum logic [1:0] {
    ACT_OFF   = 2'd0,
    ACT_DRIVE = 2'd1,
    ACT_BRAKE = 2'd2
  } drive_action_e;

  // what the back end has to do with one angle sample
  typedef enum logic [2:0] {
    CLS_IDLE = 3'd0,  // not started: output off, no state change
    CLS_STOP = 3'd1,  // zero speed: off, drop latched sector
    CLS_FWD  = 3'd2,
    CLS_REV  = 3'd3,
    CLS_DYN  = 3'd4,
    CLS_HOLD = 3'd5
  } item_cls_e;

  typedef struct packed {
    item_cls_e          cls;
    logic [SPEED_W-1:0] duty;
    logic [ANGLE_W-1:0] angle;  // offset and advance already applied
  } q_entry_t;

  // remainder mod 6 of a quotient 0..63
  function automatic logic [SECT_W-1:0] mod6(input logic [QUOT_W-1:0] q);
    logic [SECT_W-1:0] r;
    case (q) inside
      [6'd0:6'd5]:   r = SECT_W'(q);
      [6'd6:6'd11]:  r = SECT_W'(q - 6'd6);
      [6'd12:6'd17]: r = SECT_W'(q - 6'd12);
      [6'd18:6'd23]: r = SECT_W'(q - 6'd18);
      [6'd24:6'd29]: r = SECT_W'(q - 6'd24);
      [6'd30:6'd35]: r = SECT_W'(q - 6'd30);
      [6'd36:6'd41]: r = SECT_W'(q - 6'd36);
      [6'd42:6'd47]: r = SECT_W'(q - 6'd42);
      [6'd48:6'd53]: r = SECT_W'(q - 6'd48);
      [6'd54:6'd59]: r = SECT_W'(q - 6'd54);
      default:       r = SECT_W'(q - 6'd60);
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/bldc_front.sv -----
// front end: start detector, command decode, angle preparation
// depends on bldc_pkg
module bldc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [7:0]                    command_byte_i,
  input  logic [bldc_pkg::ANGLE_W-1:0]  rotor_angle_i,
  input  logic [bldc_pkg::ANGLE_W-1:0]  angle_offset_i,
  input  logic [bldc_pkg::ANGLE_W-1:0]  forward_advance_i,
  input  logic [bldc_pkg::ANGLE_W-1:0]  reverse_advance_i,
  input  logic                          q_ready_i,
  output logic                          q_push_o,
  output bldc_pkg::q_entry_t            q_entry_o
);
  import bldc_pkg::*;

  start_stage_e        stage_q, stage_d;
  brake_mode_e         brake_q, brake_d;
  logic                rev_q, rev_d;
  logic [SPEED_W-1:0]  speed_q, speed_d;
  logic                cmd_beat;
  logic [ANGLE_W-1:0]  elec;
  logic [5:0]          spd;

  assign cmd_beat = in_valid_i && q_ready_i && !opcode_i;
  assign spd      = command_byte_i[5:0];

  // next state
  always_comb begin
    stage_d = stage_q;
    brake_d = brake_q;
    rev_d   = rev_q;
    speed_d = speed_q;
    if (cmd_beat) begin
      unique case (stage_q)
        ST_WAIT_FF: if (command_byte_i == START_BYTE_0) stage_d = ST_WAIT_00;
        ST_WAIT_00: if (command_byte_i == START_BYTE_1) stage_d = ST_WAIT_80;
        ST_WAIT_80: if (command_byte_i == START_BYTE_2) stage_d = ST_RUN;
        ST_RUN: begin
          if (!command_byte_i[7]) begin
            rev_d = command_byte_i[6];
            if (spd == SPD_DYN_BRAKE) begin
              brake_d = BRK_DYN;
              speed_d = SPEED_W'(spd);
            end else if (spd == SPD_HOLD_BRAKE) begin
              brake_d = BRK_HOLD;
              speed_d = SPEED_W'(spd);
            end else begin
              brake_d = BRK_NONE;
              speed_d = {spd, 1'b0};
            end
          end
        end
        default: stage_d = ST_WAIT_FF;
      endcase
    end
  end

  // outputs: classify angle samples and prepare the lookup angle
  always_comb begin
    in_ready_o      = q_ready_i;
    q_push_o        = in_valid_i && q_ready_i && opcode_i;
    elec            = ~(rotor_angle_i - angle_offset_i);
    q_entry_o.duty  = speed_q;
    q_entry_o.angle = elec + reverse_advance_i;
    q_entry_o.cls   = CLS_IDLE;
    if (stage_q == ST_RUN) begin
      unique case (brake_q)
        BRK_NONE: begin
          if (speed_q == '0) begin
            q_entry_o.cls = CLS_STOP;
          end else if (rev_q) begin
            q_entry_o.cls = CLS_REV;
          end else begin
            q_entry_o.cls   = CLS_FWD;
            q_entry_o.angle = elec - forward_advance_i;
          end
        end
        BRK_DYN:  q_entry_o.cls = CLS_DYN;
        BRK_HOLD: q_entry_o.cls = CLS_HOLD;
        default:  q_entry_o.cls = CLS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= ST_WAIT_FF;
      brake_q <= BRK_NONE;
      rev_q   <= 1'b0;
      speed_q <= '0;
    end else begin
      stage_q <= stage_d;
      brake_q <= brake_d;
      rev_q   <= rev_d;
      speed_q <= speed_d;
    end
  end

endmodule

// ----- rtl/bldc_fifo.sv -----
// short queue of classified angle samples between front and back end
// depends on bldc_pkg
module bldc_fifo #(
  parameter int unsigned DEPTH = bldc_pkg::FIFO_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bldc_pkg::q_entry_t wr_entry_i,
  output logic               ready_o,
  input  logic               pop_i,
  output logic               valid_o,
  output bldc_pkg::q_entry_t rd_entry_o
);
  import bldc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  q_entry_t           mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;

  assign ready_o    = (count_q != CNT_FULL);
  assign valid_o    = (count_q != '0);
  assign rd_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    if (pop_i)  rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    if (push_i && !pop_i)      count_d = count_q + 1'b1;
    else if (!push_i && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wr_entry_i;
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> count_q != CNT_FULL) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0) else $error("pop from empty queue");
  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i && count_q == '0) |=> valid_o) else $error("pushed beat lost");

endmodule

// ----- rtl/bldc_back.sv -----
// back end: sector lookup, latched-sector state and output register
// depends on bldc_pkg
module bldc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  bldc_pkg::q_entry_t            q_entry_i,
  output logic                          q_pop_o,
  input  logic [bldc_pkg::DUTY_W-1:0]   hold_duty_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    drive_action_o,
  output logic [bldc_pkg::SECT_W-1:0]   sector_o,
  output logic [bldc_pkg::DUTY_W-1:0]   duty_o
);
  import bldc_pkg::*;

  logic                 out_valid_q;
  drive_action_e        action_q, action_d;
  logic [SECT_W-1:0]    sector_q, sector_d;
  logic [DUTY_W-1:0]    duty_q, duty_d;
  logic                 sv_q, sv_d;
  logic [SECT_W-1:0]    last_q, last_d;
  logic [PROD_W-1:0]    prod;
  logic [SECT_W-1:0]    raw;

  assign q_pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  // floor(2v/195) mod 6
  assign prod = PROD_W'({q_entry_i.angle, 1'b0}) * PROD_W'(SECTOR_RECIP);
  assign raw  = mod6(prod[SECTOR_SHIFT +: QUOT_W]);

  always_comb begin
    sv_d     = sv_q;
    last_d   = last_q;
    action_d = ACT_OFF;
    duty_d   = '0;
    unique case (q_entry_i.cls)
      CLS_IDLE: ;
      CLS_STOP: sv_d = 1'b0;
      CLS_FWD: begin
        sv_d     = 1'b1;
        last_d   = (raw == '0) ? SECT_W'(5) : raw - 1'b1;
        action_d = ACT_DRIVE;
        duty_d   = DUTY_W'(q_entry_i.duty);
      end
      CLS_REV: begin
        sv_d     = 1'b1;
        last_d   = (raw == SECT_W'(5)) ? '0 : raw + 1'b1;
        action_d = ACT_DRIVE;
        duty_d   = DUTY_W'(q_entry_i.duty);
      end
      CLS_DYN: begin
        sv_d     = 1'b0;
        action_d = ACT_BRAKE;
      end
      CLS_HOLD: begin
        if (!sv_q) begin
          sv_d   = 1'b1;
          last_d = raw;
        end
        action_d = ACT_DRIVE;
        duty_d   = hold_duty_i;
      end
      default: ;
    endcase
    sector_d = (action_d == ACT_DRIVE) ? last_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sv_q        <= 1'b0;
      last_q      <= '0;
    end else begin
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
        sv_q        <= sv_d;
        last_q      <= last_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      action_q <= action_d;
      sector_q <= sector_d;
      duty_q   <= duty_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign drive_action_o = action_q;
  assign sector_o       = sector_q;
  assign duty_o         = duty_q;

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && action_q != ACT_DRIVE) |-> (sector_q == '0 && duty_q == '0))
    else $error("sector or duty set without drive");
  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> sector_q <= SECT_W'(5)) else $error("sector out of range");
  a_hold_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_entry_i.cls == CLS_HOLD) |=> sv_q) else $error("hold did not latch");

endmodule

// ----- rtl/bldc_command_and_commutation.sv -----
// top level of the bldc command decoder and six-step commutation block
// depends on bldc_pkg, bldc_front, bldc_fifo, bldc_back
//
// usage:
//   input channel (in_valid_i/in_ready_o) carries one beat per item: opcode_i
//   0 is a serial command byte (command_byte_i), 1 a raw rotor angle sample
//   (rotor_angle_i). command bytes first walk the start sequence ff, 00, 80;
//   after that they set direction, speed or brake mode and give no result.
//   every angle sample gives exactly one beat on the output channel
//   (out_valid_o/out_ready_i): drive_action_o, sector_o, duty_o.
//   path: an accepted sample is written into the queue and from there into
//   the output register once that register is free.
//   throughput: one item per cycle while the queue has room; the back end
//   has a single sector multiplier; commands and samples may be mixed freely.
//   receiver stall: the result holds in the output register, further samples
//   collect in a small queue (FIFO_DEPTH entries); in_ready_o drops only
//   when that queue is full.
//   reset: start detector back to waiting for ff, stopped, no brake, no
//   latched sector, queue empty; registers back to offset 0, forward
//   advance 123, reverse advance 43, hold duty 120. the user must write the
//   registers over the apb port only while the block is idle; not checked.
module bldc_command_and_commutation #(
  parameter int unsigned FIFO_DEPTH = bldc_pkg::FIFO_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [7:0]                    command_byte_i,
  input  logic [bldc_pkg::ANGLE_W-1:0]  rotor_angle_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    drive_action_o,
  output logic [bldc_pkg::SECT_W-1:0]   sector_o,
  output logic [bldc_pkg::DUTY_W-1:0]   duty_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bldc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bldc_pkg::*;

  logic [ANGLE_W-1:0]   angle_offset_q, forward_advance_q, reverse_advance_q;
  logic [DUTY_W-1:0]    hold_duty_q;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  logic                 q_push, q_ready, q_pop, q_valid;
  q_entry_t             q_wr_entry, q_rd_entry;

  // register file: write in the apb access phase, zero wait states
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1 -: REG_IDX_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_offset_q    <= ANGLE_OFFSET_RST;
      forward_advance_q <= FORWARD_ADVANCE_RST;
      reverse_advance_q <= REVERSE_ADVANCE_RST;
      hold_duty_q       <= HOLD_DUTY_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ANGLE_OFFSET:    angle_offset_q    <= pwdata[ANGLE_W-1:0];
        REG_FORWARD_ADVANCE: forward_advance_q <= pwdata[ANGLE_W-1:0];
        REG_REVERSE_ADVANCE: reverse_advance_q <= pwdata[ANGLE_W-1:0];
        REG_HOLD_DUTY:       hold_duty_q       <= pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    unique case (reg_idx)
      REG_ANGLE_OFFSET:    prdata = 32'(angle_offset_q);
      REG_FORWARD_ADVANCE: prdata = 32'(forward_advance_q);
      REG_REVERSE_ADVANCE: prdata = 32'(reverse_advance_q);
      REG_HOLD_DUTY:       prdata = 32'(hold_duty_q);
      default:             prdata = '0;
    endcase
  end

  // front end: start detector and command state, classifies samples
  bldc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .opcode_i          (opcode_i),
    .command_byte_i    (command_byte_i),
    .rotor_angle_i     (rotor_angle_i),
    .angle_offset_i    (angle_offset_q),
    .forward_advance_i (forward_advance_q),
    .reverse_advance_i (reverse_advance_q),
    .q_ready_i         (q_ready),
    .q_push_o          (q_push),
    .q_entry_o         (q_wr_entry)
  );

  // decouples front end from a stalled output
  bldc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .wr_entry_i (q_wr_entry),
    .ready_o    (q_ready),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .rd_entry_o (q_rd_entry)
  );

  // back end: sector math, hold latch, output register
  bldc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_entry_i      (q_rd_entry),
    .q_pop_o        (q_pop),
    .hold_duty_i    (hold_duty_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .drive_action_o (drive_action_o),
    .sector_o       (sector_o),
    .duty_o         (duty_o)
  );

endmodule

// ----- dv/bldc_command_and_commutation_tb.sv -----
// self-checking testbench for bldc_command_and_commutation: command bytes and
// angle samples in, drive beats out, checked against an in-bench predictor
// depends on bldc_pkg and the rtl of bldc_command_and_commutation
module bldc_command_and_commutation_tb;
  import bldc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_ITEMS  = 360;   // five phases, about 1800 items
  localparam int unsigned LONG_HOLD_AT = 500;   // item count that triggers the long stall
  localparam int unsigned LONG_HOLD    = 300;   // cycles the receiver holds off
  localparam int unsigned SETTLE       = 4;     // cycles after the last beat before idle
  localparam int unsigned MAX_LOGGED   = 50;

  // one expected drive beat
  typedef struct {
    drive_action_e act;
    logic [SECT_W-1:0] sec;
    logic [DUTY_W-1:0] duty;
  } drive_t;

  // ---------------------------------------------------------------------------
  // predictor and store of expected drive beats
  // ---------------------------------------------------------------------------
  class drive_checker;
    logic [ANGLE_W-1:0] angle_zero;
    logic [ANGLE_W-1:0] fwd_adv;
    logic [ANGLE_W-1:0] rev_adv;
    logic [DUTY_W-1:0]  hold_level;
    start_stage_e       stage;
    logic               rev_dir;
    logic [SPEED_W-1:0] speed;
    brake_mode_e        brake;
    logic               sect_valid;
    logic [SECT_W-1:0]  last_sect;
    drive_t             pending_drives[$];
    int                 errors;

    function new();
      angle_zero = ANGLE_OFFSET_RST;
      fwd_adv    = FORWARD_ADVANCE_RST;
      rev_adv    = REVERSE_ADVANCE_RST;
      hold_level = HOLD_DUTY_RST;
      stage      = ST_WAIT_FF;
      rev_dir    = 1'b0;
      speed      = '0;
      brake      = BRK_NONE;
      sect_valid = 1'b0;
      last_sect  = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_ANGLE_OFFSET:    angle_zero = val[ANGLE_W-1:0];
        REG_FORWARD_ADVANCE: fwd_adv    = val[ANGLE_W-1:0];
        REG_REVERSE_ADVANCE: rev_adv    = val[ANGLE_W-1:0];
        default:             hold_level = val[DUTY_W-1:0];
      endcase
    endfunction

    function int unsigned pending();
      return pending_drives.size();
    endfunction

    // floor(v / 97.5) mod 6
    function int sixth_of(logic [ANGLE_W-1:0] v);
      int q;
      q = (2 * int'(v)) / 195;
      return q % 6;
    endfunction

    function void take_command(logic [7:0] b);
      case (stage)
        ST_WAIT_FF: if (b == START_BYTE_0) stage = ST_WAIT_00;
        ST_WAIT_00: if (b == START_BYTE_1) stage = ST_WAIT_80;
        ST_WAIT_80: if (b == START_BYTE_2) stage = ST_RUN;
        default: begin
          if (!b[7]) begin
            rev_dir = b[6];
            if (b[5:0] == SPD_DYN_BRAKE) begin
              brake = BRK_DYN;
              speed = {1'b0, b[5:0]};
            end else if (b[5:0] == SPD_HOLD_BRAKE) begin
              brake = BRK_HOLD;
              speed = {1'b0, b[5:0]};
            end else begin
              brake = BRK_NONE;
              speed = {b[5:0], 1'b0};
            end
          end
        end
      endcase
    endfunction

    function drive_t predict_drive(logic [ANGLE_W-1:0] raw);
      drive_t             d;
      logic [ANGLE_W-1:0] e;
      logic [ANGLE_W-1:0] v;
      d = '{act: ACT_OFF, sec: '0, duty: '0};
      if (stage != ST_RUN) return d;
      e = ~(raw - angle_zero);  // 4095 minus the offset-corrected angle
      case (brake)
        BRK_NONE: begin
          if (speed == '0) begin
            sect_valid = 1'b0;
          end else begin
            sect_valid = 1'b1;
            if (rev_dir) begin
              v = e + rev_adv;
              last_sect = SECT_W'((sixth_of(v) + 1) % 6);
            end else begin
              v = e - fwd_adv;
              last_sect = SECT_W'((sixth_of(v) + 5) % 6);
            end
            d = '{act: ACT_DRIVE, sec: last_sect, duty: {1'b0, speed}};
          end
        end
        BRK_DYN: begin
          sect_valid = 1'b0;
          d.act = ACT_BRAKE;
        end
        default: begin
          // hold brake latches only when nothing is latched yet
          if (!sect_valid) begin
            v = e + rev_adv;
            last_sect = SECT_W'(sixth_of(v));
            sect_valid = 1'b1;
          end
          d = '{act: ACT_DRIVE, sec: last_sect, duty: hold_level};
        end
      endcase
      return d;
    endfunction

    function void note_item(logic op, logic [7:0] b, logic [ANGLE_W-1:0] a);
      if (!op) take_command(b);
      else pending_drives.push_back(predict_drive(a));
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_LOGGED) $display("mismatch: %s", msg);
    endtask

    task check_result(drive_t got);
      drive_t want;
      if (pending_drives.size() == 0) begin
        report($sformatf("drive beat with nothing expected: act=%0d sec=%0d duty=%0d",
                         got.act, got.sec, got.duty));
        return;
      end
      want = pending_drives.pop_front();
      if (got.act !== want.act)
        report($sformatf("drive_action got %0d want %0d", got.act, want.act));
      if (got.sec !== want.sec)
        report($sformatf("sector got %0d want %0d", got.sec, want.sec));
      if (got.duty !== want.duty)
        report($sformatf("duty got %0d want %0d", got.duty, want.duty));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // signals, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                opcode_i       = 1'b0;
  logic [7:0]          command_byte_i = '0;
  logic [ANGLE_W-1:0]  rotor_angle_i  = '0;
  logic                out_ready_i    = 1'b0;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [PADDR_W-1:0]  paddr          = '0;
  logic [31:0]         pwdata         = '0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [1:0]          drive_action_o;
  logic [SECT_W-1:0]   sector_o;
  logic [DUTY_W-1:0]   duty_o;
  logic [31:0]         prdata;
  logic                pready;

  drive_checker sb;
  int unsigned  cycle_count     = 0;
  int unsigned  items_sent      = 0;
  int unsigned  burst_left      = 0;
  bit           long_hold_done  = 1'b0;

  bldc_command_and_commutation uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .command_byte_i (command_byte_i),
    .rotor_angle_i  (rotor_angle_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .drive_action_o (drive_action_o),
    .sector_o       (sector_o),
    .duty_o         (duty_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run-length guard
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sender tasks
  // ---------------------------------------------------------------------------

  // hold valid low for a gap of length n; a zero gap keeps valid up for the next beat
  task rest(int unsigned n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // offer one item and return once accepted; valid stays high unless a burst ends
  task send_item(logic op, logic [7:0] b, logic [ANGLE_W-1:0] a);
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    command_byte_i <= b;
    rotor_angle_i  <= a;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(op, b, a);
    items_sent++;
    // bursts of random length, now and then a long one with no gaps at all
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 16);
      rest($urandom_range(1, 8));
    end
  endtask

  // unused payload fields carry random bits so every input bit toggles
  task send_cmd(logic [7:0] b);
    send_item(1'b0, b, ANGLE_W'($urandom_range(0, 4095)));
  endtask

  task send_angle(logic [ANGLE_W-1:0] a);
    send_item(1'b1, 8'($urandom_range(0, 255)), a);
  endtask

  // sender waits until every drive beat is back, then lets the block settle
  task drain();
    rest(1);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task reg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task set_regs(logic [ANGLE_W-1:0] zero, logic [ANGLE_W-1:0] fwd,
                logic [ANGLE_W-1:0] rev, logic [DUTY_W-1:0] hold);
    reg_write(REG_ANGLE_OFFSET, 32'(zero));
    reg_write(REG_FORWARD_ADVANCE, 32'(fwd));
    reg_write(REG_REVERSE_ADVANCE, 32'(rev));
    reg_write(REG_HOLD_DUTY, 32'(hold));
  endtask

  // command byte once started: mostly well-formed, weighted toward stop and brakes
  function logic [7:0] pick_command();
    int          r;
    logic [5:0]  s;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h80 | 8'($urandom_range(0, 127));  // ignored after start
    if (r < 20)      s = '0;
    else if (r < 32) s = SPD_DYN_BRAKE;
    else if (r < 44) s = SPD_HOLD_BRAKE;
    else             s = 6'($urandom_range(1, 61));
    return {1'b0, 1'($urandom_range(0, 1)), s};
  endfunction

  // random phase: about a quarter commands, the rest angle samples
  task random_phase();
    int unsigned n;
    logic [7:0]  b;
    int unsigned r;
    n = 0;
    while (n < PHASE_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        b = pick_command();
        send_cmd(b);
        if (!b[7]) n++;
      end else begin
        r = $urandom_range(0, 19);
        if (r == 0)      send_angle('0);
        else if (r == 1) send_angle('1);
        else             send_angle(ANGLE_W'($urandom_range(0, 4095)));
        n++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall pattern of its own, plus one long hold-off mid run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned seg_left;
    int unsigned mode;
    seg_left = 0;
    mode     = 0;
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && items_sent >= LONG_HOLD_AT) begin
        // sender keeps offering, so the queue fills and in_ready_o drops
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_done = 1'b1;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 120);
        mode     = $urandom_range(0, 3);
      end
      seg_left--;
      case (mode)
        0:       out_ready_i <= 1'b1;                        // no stalls
        1:       out_ready_i <= 1'($urandom_range(0, 1));    // coin flip
        2:       out_ready_i <= ($urandom_range(0, 3) == 0); // mostly stalled
        default: out_ready_i <= seg_left[0];                 // alternates high and low
      endcase
    end
  end

  // output monitor: every accepted drive beat goes to the checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{act: drive_action_e'(drive_action_o), sec: sector_o, duty: duty_o});
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = 5;

    // directed part, reset register values
    send_angle('0);               // not started: all off
    send_cmd(8'h00);              // wrong byte while waiting for ff
    send_cmd(START_BYTE_0);
    send_cmd(8'h55);              // wrong byte while waiting for 00
    send_cmd(START_BYTE_1);
    send_angle('1);               // still not started
    send_cmd(8'h7F);              // wrong byte while waiting for 80
    send_cmd(START_BYTE_2);
    send_angle(12'd100);          // started, zero speed: off
    send_cmd(8'h01);              // forward, lowest speed
    send_angle('0);
    send_angle('1);
    send_cmd(8'h3D);              // forward, highest plain speed
    send_angle(12'd2048);
    send_cmd(8'hC5);              // bit7 set after start: ignored
    send_cmd(8'h7D);              // reverse, highest plain speed
    send_angle('0);
    send_angle('1);
    send_cmd(8'h7F);              // hold brake right after driving keeps the sector
    send_angle(12'd1234);
    send_cmd(8'h3E);              // dynamic brake clears the latched sector
    send_angle(12'd777);
    send_cmd(8'h3F);              // hold brake latches a fresh sector
    send_angle(12'd3000);
    send_angle(12'd10);
    send_cmd(8'h40);              // reverse, zero speed: off
    send_angle(12'd500);
    drain();

    // random phases, extremes first, then random register settings
    set_regs('0, '0, '0, '0);
    random_phase();
    drain();
    set_regs('1, '1, '1, '1);
    random_phase();
    drain();
    repeat (3) begin
      set_regs(ANGLE_W'($urandom_range(0, 4095)), ANGLE_W'($urandom_range(0, 4095)),
               ANGLE_W'($urandom_range(0, 4095)), DUTY_W'($urandom_range(0, 255)));
      random_phase();
      drain();
    end

    if (sb.pending() != 0)
      sb.report($sformatf("%0d drive beats never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
